[rtl/core/pft_pkg.sv]
// ----------------------------------------------------------------------------
// Pose frame transform package
// Shared types, register indexes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package pft_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [32:0] num_t;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ROT_PAIR_0 = 3'd0;
  localparam logic [2:0] REG_ROT_PAIR_1 = 3'd1;
  localparam logic [2:0] REG_ROT_PAIR_2 = 3'd2;
  localparam logic [2:0] REG_ROT_PAIR_3 = 3'd3;
  localparam logic [2:0] REG_ROT_LAST   = 3'd4;
  localparam logic [2:0] REG_OFFSET_XY  = 3'd5;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd6;
  localparam logic [2:0] REG_SCALE      = 3'd7;

  // Which quaternion component takes half the square root.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

  localparam int SQ_STAGES = 16;
  localparam int DV_STAGES = 15;

  typedef struct packed {
    word_t [8:0] a;      // a[i*3+k] is entry (i, k) of the frame matrix
    word_t [2:0] off;
    logic [23:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [63:0] time_tag;
    word_t       px;
    word_t       py;
    word_t       pz;
    word_t       qx;
    word_t       qy;
    word_t       qz;
    word_t       qw;
  } pose_t;

  // Data that rides alongside the square root and reciprocal pipelines.
  typedef struct packed {
    logic [63:0] time_tag;
    word_t [2:0] pos;
    logic        ovf;
    num_t [3:0]  num;    // numerators for x, y, z, w
    logic [1:0]  sel;
  } side_t;

  typedef struct packed {
    logic [63:0] time_tag;
    word_t [2:0] pos;
    word_t [3:0] quat;   // x, y, z, w
    logic        ovf;
  } res_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] q;
  } dv_t;

  function automatic word_t sat32(logic signed [63:0] v);
    word_t o;
    if (v > 64'sh7fffffff) begin
      o = 32'sh7fffffff;
    end else if (v < -64'sh80000000) begin
      o = -32'sh80000000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic ovr32(logic signed [63:0] v);
    return (v > 64'sh7fffffff) || (v < -64'sh80000000);
  endfunction

  // One step of the bitwise integer square root.
  function automatic sq_t sq_step(sq_t cur, logic [63:0] bw);
    sq_t o;
    o = cur;
    if (cur.v >= cur.r + bw) begin
      o.v = cur.v - (cur.r + bw);
      o.r = (cur.r >> 1) + bw;
    end else begin
      o.r = cur.r >> 1;
    end
    return o;
  endfunction

  // One step of restoring division; the dividend bits below the window are zero.
  function automatic dv_t dv_step(dv_t cur, logic [31:0] s);
    dv_t o;
    logic [32:0] r2;
    r2 = {cur.rem, 1'b0};
    if (r2 >= {1'b0, s}) begin
      o.rem = 32'(r2 - {1'b0, s});
      o.q   = {cur.q[28:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.q   = {cur.q[28:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/core/pft_if.sv]
// ----------------------------------------------------------------------------
// Pose frame transform channels
// Valid/ready interfaces for poses in, results out and register writes.
// ----------------------------------------------------------------------------
interface pft_pose_if;
  logic               valid;
  logic               ready;
  logic        [63:0] time_tag;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;

  modport source (output valid, time_tag, pos_x, pos_y, pos_z,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, time_tag, pos_x, pos_y, pos_z,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface pft_result_if;
  logic               valid;
  logic               ready;
  logic        [63:0] time_tag_out;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_quat_x;
  logic signed [31:0] out_quat_y;
  logic signed [31:0] out_quat_z;
  logic signed [31:0] out_quat_w;
  logic               overflow;

  modport source (output valid, time_tag_out, out_pos_x, out_pos_y, out_pos_z,
                  out_quat_x, out_quat_y, out_quat_z, out_quat_w, overflow,
                  input ready);
  modport sink   (input valid, time_tag_out, out_pos_x, out_pos_y, out_pos_z,
                  out_quat_x, out_quat_y, out_quat_z, out_quat_w, overflow,
                  output ready);
endinterface

interface pft_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/pft_front.sv]
// ----------------------------------------------------------------------------
// Pose frame transform front end
// Seven stages: rotation matrix, translation, frame matrix product, output
// position, and the square root argument and numerators for the quaternion.
// ----------------------------------------------------------------------------
module pft_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  pft_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  pft_pkg::pose_t in_pose,
  output logic           out_valid,
  output pft_pkg::side_t out_side,
  output logic [63:0]    out_arg
);

  localparam logic signed [36:0] ONE37 = 37'sh40000000;
  localparam logic signed [34:0] ONE35 = 35'sh40000000;

  // Stage 1: quaternion products.
  logic               v1;
  logic [63:0]        tm1;
  pft_pkg::word_t     p1 [3];
  logic signed [34:0] xx1, yy1, zz1, xy1, xz1, yz1, xw1, yw1, zw1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm1   <= in_pose.time_tag;
      p1[0] <= in_pose.px;
      p1[1] <= in_pose.py;
      p1[2] <= in_pose.pz;
      xx1 <= 35'((64'(in_pose.qx) * 64'(in_pose.qx)) >>> 29);
      yy1 <= 35'((64'(in_pose.qy) * 64'(in_pose.qy)) >>> 29);
      zz1 <= 35'((64'(in_pose.qz) * 64'(in_pose.qz)) >>> 29);
      xy1 <= 35'((64'(in_pose.qx) * 64'(in_pose.qy)) >>> 29);
      xz1 <= 35'((64'(in_pose.qx) * 64'(in_pose.qz)) >>> 29);
      yz1 <= 35'((64'(in_pose.qy) * 64'(in_pose.qz)) >>> 29);
      xw1 <= 35'((64'(in_pose.qx) * 64'(in_pose.qw)) >>> 29);
      yw1 <= 35'((64'(in_pose.qy) * 64'(in_pose.qw)) >>> 29);
      zw1 <= 35'((64'(in_pose.qz) * 64'(in_pose.qw)) >>> 29);
    end
  end

  // Stage 2: transposed rotation matrix, rt[i*3+j] = R(j, i), saturated.
  logic               v2;
  logic [63:0]        tm2;
  pft_pkg::word_t     p2 [3];
  pft_pkg::word_t     rt2 [9];
  logic signed [36:0] rr [9];

  always_comb begin
    rr[0] = ONE37 - (37'(yy1) + 37'(zz1));
    rr[1] = 37'(xy1) + 37'(zw1);
    rr[2] = 37'(xz1) - 37'(yw1);
    rr[3] = 37'(xy1) - 37'(zw1);
    rr[4] = ONE37 - (37'(xx1) + 37'(zz1));
    rr[5] = 37'(yz1) + 37'(xw1);
    rr[6] = 37'(xz1) + 37'(yw1);
    rr[7] = 37'(yz1) - 37'(xw1);
    rr[8] = ONE37 - (37'(xx1) + 37'(yy1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm2 <= tm1;
      for (int i = 0; i < 3; i++) p2[i] <= p1[i];
      for (int i = 0; i < 9; i++) rt2[i] <= pft_pkg::sat32(64'(rr[i]));
    end
  end

  // Stage 3: products for the translation and for the frame matrix.
  logic               v3;
  logic [63:0]        tm3;
  logic signed [33:0] up3 [9];
  logic signed [33:0] ma3 [27];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm3 <= tm2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          up3[i*3+j] <= 34'((64'(rt2[i*3+j]) * 64'(p2[j])) >>> 30);
          for (int k = 0; k < 3; k++) begin
            ma3[(i*3+j)*3+k] <=
              34'((64'($signed(cfg.a[i*3+k])) * 64'(rt2[k*3+j])) >>> 30);
          end
        end
      end
    end
  end

  // Stage 4: sums.
  logic               v4;
  logic [63:0]        tm4;
  logic signed [35:0] u4 [3];
  pft_pkg::word_t     m4 [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm4 <= tm3;
      for (int i = 0; i < 3; i++) begin
        u4[i] <= 36'(up3[i*3]) + 36'(up3[i*3+1]) + 36'(up3[i*3+2]);
      end
      for (int n = 0; n < 9; n++) begin
        m4[n] <= pft_pkg::sat32(64'(36'(ma3[n*3]) + 36'(ma3[n*3+1])
                                    + 36'(ma3[n*3+2])));
      end
    end
  end

  // Stage 5: scaled translation, and the choice of quaternion branch.
  logic               v5;
  logic [63:0]        tm5;
  pft_pkg::word_t     t5 [3];
  logic               ovf5;
  pft_pkg::num_t      num5 [4];
  logic [1:0]         sel5;
  logic [63:0]        arg5;

  logic signed [63:0] tsc [3];
  logic signed [33:0] tr;
  logic signed [34:0] targ;
  logic signed [34:0] darg;
  logic [1:0]         ii;
  pft_pkg::word_t     mii, mjj, mkk;
  pft_pkg::num_t      nsel [4];
  logic [1:0]         selc;
  logic [63:0]        argc;
  logic               ovfc;

  always_comb begin
    ovfc = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tsc[i] = (64'(-37'(u4[i])) * 64'($signed({1'b0, cfg.scale}))) >>> 16;
      ovfc   = ovfc | pft_pkg::ovr32(tsc[i]);
    end

    tr   = 34'(m4[0]) + 34'(m4[4]) + 34'(m4[8]);
    targ = 35'(tr) + ONE35;

    ii = pft_pkg::SEL_X;
    if (m4[4] > m4[0]) ii = pft_pkg::SEL_Y;
    if (ii == pft_pkg::SEL_Y) begin
      if (m4[8] > m4[4]) ii = pft_pkg::SEL_Z;
    end else begin
      if (m4[8] > m4[0]) ii = pft_pkg::SEL_Z;
    end

    case (ii)
      pft_pkg::SEL_Y: begin
        mii = m4[4]; mjj = m4[8]; mkk = m4[0];
      end
      pft_pkg::SEL_Z: begin
        mii = m4[8]; mjj = m4[0]; mkk = m4[4];
      end
      default: begin
        mii = m4[0]; mjj = m4[4]; mkk = m4[8];
      end
    endcase
    darg = 35'(mii) - 35'(mjj) - 35'(mkk) + ONE35;

    for (int n = 0; n < 4; n++) nsel[n] = '0;
    if (tr > 34'sd0) begin
      selc    = pft_pkg::SEL_W;
      argc    = {1'b0, targ[32:0], 30'd0};
      nsel[0] = 33'(m4[7]) - 33'(m4[5]);
      nsel[1] = 33'(m4[2]) - 33'(m4[6]);
      nsel[2] = 33'(m4[3]) - 33'(m4[1]);
    end else begin
      selc = ii;
      argc = {1'b0, darg[32:0], 30'd0};
      case (ii)
        pft_pkg::SEL_Y: begin
          nsel[3] = 33'(m4[2]) - 33'(m4[6]);
          nsel[2] = 33'(m4[7]) + 33'(m4[5]);
          nsel[0] = 33'(m4[1]) + 33'(m4[3]);
        end
        pft_pkg::SEL_Z: begin
          nsel[3] = 33'(m4[3]) - 33'(m4[1]);
          nsel[0] = 33'(m4[2]) + 33'(m4[6]);
          nsel[1] = 33'(m4[5]) + 33'(m4[7]);
        end
        default: begin
          nsel[3] = 33'(m4[7]) - 33'(m4[5]);
          nsel[1] = 33'(m4[3]) + 33'(m4[1]);
          nsel[2] = 33'(m4[6]) + 33'(m4[2]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm5  <= tm4;
      ovf5 <= ovfc;
      sel5 <= selc;
      arg5 <= argc;
      for (int i = 0; i < 3; i++) t5[i] <= pft_pkg::sat32(tsc[i]);
      for (int n = 0; n < 4; n++) num5[n] <= nsel[n];
    end
  end

  // Stage 6: frame matrix times translation.
  logic               v6;
  logic [63:0]        tm6;
  logic signed [33:0] at6 [9];
  logic               ovf6;
  pft_pkg::num_t      num6 [4];
  logic [1:0]         sel6;
  logic [63:0]        arg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm6  <= tm5;
      ovf6 <= ovf5;
      sel6 <= sel5;
      arg6 <= arg5;
      for (int n = 0; n < 4; n++) num6[n] <= num5[n];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          at6[i*3+k] <= 34'((64'($signed(cfg.a[i*3+k])) * 64'(t5[k])) >>> 30);
        end
      end
    end
  end

  // Stage 7: add the offset and saturate the position.
  logic               v7;
  pft_pkg::side_t     sd7;
  logic [63:0]        arg7;
  logic signed [35:0] pacc [3];
  logic               povf;

  always_comb begin
    povf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pacc[i] = 36'(at6[i*3]) + 36'(at6[i*3+1]) + 36'(at6[i*3+2])
              + 36'($signed(cfg.off[i]));
      povf = povf | pft_pkg::ovr32(64'(pacc[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd7.time_tag <= tm6;
      sd7.ovf      <= ovf6 | povf;
      sd7.sel      <= sel6;
      arg7         <= arg6;
      for (int i = 0; i < 3; i++) sd7.pos[i] <= pft_pkg::sat32(64'(pacc[i]));
      for (int n = 0; n < 4; n++) sd7.num[n] <= num6[n];
    end
  end

  assign out_valid = v7;
  assign out_side  = sd7;
  assign out_arg   = arg7;

endmodule

[rtl/core/pft_sqrt.sv]
// ----------------------------------------------------------------------------
// Pose frame transform square root
// Pipelined bitwise integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module pft_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  pft_pkg::side_t in_side,
  input  logic [63:0]    in_arg,
  output logic           out_valid,
  output pft_pkg::side_t out_side,
  output logic [31:0]    out_root
);

  localparam int N = pft_pkg::SQ_STAGES;

  logic           vd [N];
  pft_pkg::sq_t   st [N];
  pft_pkg::side_t sd [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < N; g++) vd[g] <= 1'b0;
    end else if (adv) begin
      vd[0] <= in_valid;
      for (int g = 1; g < N; g++) vd[g] <= vd[g-1];
    end
  end

  // The test bit starts at the top even position and falls by four per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= in_side;
      st[0] <= pft_pkg::sq_step(pft_pkg::sq_step('{v: in_arg, r: 64'd0},
                                                 64'd1 << 62), 64'd1 << 60);
      for (int g = 1; g < N; g++) begin
        sd[g] <= sd[g-1];
        st[g] <= pft_pkg::sq_step(pft_pkg::sq_step(st[g-1], 64'd1 << (62 - 4*g)),
                                  64'd1 << (60 - 4*g));
      end
    end
  end

  assign out_valid = vd[N-1];
  assign out_side  = sd[N-1];
  assign out_root  = st[N-1].r[31:0];

endmodule

[rtl/core/pft_recip.sv]
// ----------------------------------------------------------------------------
// Pose frame transform reciprocal
// Pipelined restoring division of 2^59 by the root, two quotient bits a stage.
// ----------------------------------------------------------------------------
module pft_recip (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  pft_pkg::side_t in_side,
  input  logic [31:0]    in_root,
  output logic           out_valid,
  output pft_pkg::side_t out_side,
  output logic [31:0]    out_root,
  output logic [29:0]    out_recip
);

  localparam int N = pft_pkg::DV_STAGES;

  // The root is at least 2^30, so the quotient fits in 30 bits and the
  // partial remainder starts at the dividend's top part, 2^29.
  localparam logic [31:0] REM_INIT = 32'h2000_0000;

  logic           vd [N];
  pft_pkg::dv_t   dv [N];
  logic [31:0]    rt [N];
  pft_pkg::side_t sd [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < N; g++) vd[g] <= 1'b0;
    end else if (adv) begin
      vd[0] <= in_valid;
      for (int g = 1; g < N; g++) vd[g] <= vd[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= in_side;
      rt[0] <= in_root;
      dv[0] <= pft_pkg::dv_step(pft_pkg::dv_step('{rem: REM_INIT, q: 30'd0},
                                                 in_root), in_root);
      for (int g = 1; g < N; g++) begin
        sd[g] <= sd[g-1];
        rt[g] <= rt[g-1];
        dv[g] <= pft_pkg::dv_step(pft_pkg::dv_step(dv[g-1], rt[g-1]), rt[g-1]);
      end
    end
  end

  assign out_valid = vd[N-1];
  assign out_side  = sd[N-1];
  assign out_root  = rt[N-1];
  assign out_recip = dv[N-1].q;

endmodule

[rtl/core/pft_quat.sv]
// ----------------------------------------------------------------------------
// Pose frame transform quaternion assembly
// Scales the numerators by the reciprocal, saturates and places half the root.
// ----------------------------------------------------------------------------
module pft_quat (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  pft_pkg::side_t in_side,
  input  logic [31:0]    in_root,
  input  logic [29:0]    in_recip,
  output logic           out_valid,
  output pft_pkg::res_t  out_res
);

  logic               v1;
  logic signed [33:0] pr1 [4];
  logic [30:0]        half1;
  pft_pkg::side_t     sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1   <= in_side;
      half1 <= in_root[31:1];
      for (int n = 0; n < 4; n++) begin
        pr1[n] <= 34'((64'(in_side.num[n]) * 64'($signed({1'b0, in_recip}))) >>> 30);
      end
    end
  end

  logic          v2;
  pft_pkg::res_t rs2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs2.time_tag <= sd1.time_tag;
      rs2.pos      <= sd1.pos;
      rs2.ovf      <= sd1.ovf;
      for (int n = 0; n < 4; n++) begin
        if (sd1.sel == 2'(n)) begin
          rs2.quat[n] <= {1'b0, half1};
        end else begin
          rs2.quat[n] <= pft_pkg::sat32(64'(pr1[n]));
        end
      end
    end
  end

  assign out_valid = v2;
  assign out_res   = rs2;

endmodule

[rtl/core/pose_frame_transform.sv]
// Throughput: one pose per cycle; the 40 pipeline stages advance together
// and stall only when the two-entry output buffer is full.
// The square root and reciprocal stages set the depth, two bits per stage.
// Reset clears every valid bit and the buffer, and loads the identity frame
// matrix, zero offset and unit scale; configuration is taken in any cycle.
// ----------------------------------------------------------------------------
// Pose frame transform
// Maps poses into a configured frame and rebuilds the rotation quaternion.
// ----------------------------------------------------------------------------
module pose_frame_transform (
  input  logic clk,
  input  logic rst,
  pft_pose_if.sink     pose,
  pft_result_if.source result,
  pft_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [63:0] rot_pair [4];
  logic [31:0] rot_last;
  logic [63:0] offset_xy;
  logic [31:0] offset_z;
  logic [23:0] scale_factor;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_pair[0]  <= 64'h0000_0000_4000_0000;
      rot_pair[1]  <= 64'd0;
      rot_pair[2]  <= 64'h0000_0000_4000_0000;
      rot_pair[3]  <= 64'd0;
      rot_last     <= 32'h4000_0000;
      offset_xy    <= 64'd0;
      offset_z     <= 32'd0;
      scale_factor <= 24'h01_0000;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        pft_pkg::REG_ROT_PAIR_0: rot_pair[0]  <= cfg.data;
        pft_pkg::REG_ROT_PAIR_1: rot_pair[1]  <= cfg.data;
        pft_pkg::REG_ROT_PAIR_2: rot_pair[2]  <= cfg.data;
        pft_pkg::REG_ROT_PAIR_3: rot_pair[3]  <= cfg.data;
        pft_pkg::REG_ROT_LAST:   rot_last     <= cfg.data[31:0];
        pft_pkg::REG_OFFSET_XY:  offset_xy    <= cfg.data;
        pft_pkg::REG_OFFSET_Z:   offset_z     <= cfg.data[31:0];
        pft_pkg::REG_SCALE:      scale_factor <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  pft_pkg::cfg_t cfg_w;

  always_comb begin
    cfg_w.a[0]   = rot_pair[0][31:0];
    cfg_w.a[1]   = rot_pair[0][63:32];
    cfg_w.a[2]   = rot_pair[1][31:0];
    cfg_w.a[3]   = rot_pair[1][63:32];
    cfg_w.a[4]   = rot_pair[2][31:0];
    cfg_w.a[5]   = rot_pair[2][63:32];
    cfg_w.a[6]   = rot_pair[3][31:0];
    cfg_w.a[7]   = rot_pair[3][63:32];
    cfg_w.a[8]   = rot_last;
    cfg_w.off[0] = offset_xy[31:0];
    cfg_w.off[1] = offset_xy[63:32];
    cfg_w.off[2] = offset_z;
    cfg_w.scale  = scale_factor;
  end

  // Output buffer state; the pipeline moves only while a slot is free.
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       adv;

  assign adv        = (cnt != 2'd2);
  assign pose.ready = adv;

  pft_pkg::pose_t in_pose;

  always_comb begin
    in_pose.time_tag = pose.time_tag;
    in_pose.px       = pose.pos_x;
    in_pose.py       = pose.pos_y;
    in_pose.pz       = pose.pos_z;
    in_pose.qx       = pose.quat_x;
    in_pose.qy       = pose.quat_y;
    in_pose.qz       = pose.quat_z;
    in_pose.qw       = pose.quat_w;
  end

  logic           f_valid;
  pft_pkg::side_t f_side;
  logic [63:0]    f_arg;

  pft_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg_w),
    .in_valid  (pose.valid),
    .in_pose   (in_pose),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_arg   (f_arg)
  );

  logic           s_valid;
  pft_pkg::side_t s_side;
  logic [31:0]    s_root;

  pft_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_arg    (f_arg),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_root  (s_root)
  );

  logic           d_valid;
  pft_pkg::side_t d_side;
  logic [31:0]    d_root;
  logic [29:0]    d_recip;

  pft_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_valid),
    .in_side   (s_side),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_root  (d_root),
    .out_recip (d_recip)
  );

  logic          q_valid;
  pft_pkg::res_t q_res;

  pft_quat u_quat (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_root   (d_root),
    .in_recip  (d_recip),
    .out_valid (q_valid),
    .out_res   (q_res)
  );

  // Two-entry output buffer.
  pft_pkg::res_t buf_mem [2];
  logic          push;
  logic          pop;

  assign push = adv && q_valid;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wp] <= q_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  pft_pkg::res_t head;
  assign head = buf_mem[rp];

  assign result.valid        = (cnt != 2'd0);
  assign result.time_tag_out = head.time_tag;
  assign result.out_pos_x    = head.pos[0];
  assign result.out_pos_y    = head.pos[1];
  assign result.out_pos_z    = head.pos[2];
  assign result.out_quat_x   = head.quat[0];
  assign result.out_quat_y   = head.quat[1];
  assign result.out_quat_z   = head.quat[2];
  assign result.out_quat_w   = head.quat[3];
  assign result.overflow     = head.ovf;

endmodule

[rtl/core/pft_checker.sv]
// ----------------------------------------------------------------------------
// Pose frame transform checker
// Port-level assertions on the pose and result channels.
// ----------------------------------------------------------------------------
module pft_assertions (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_time
);

  // A result that is not taken stays offered with the same timestamp.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_time))
    else $error("result changed while stalled");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // With nothing buffered the block always takes a pose.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // The input stalls only after a result was offered and not taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

endmodule

bind pose_frame_transform pft_assertions u_pft_assertions (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pose.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_time  (result.time_tag_out)
);

[bench/pft_tb_if.sv]
// ----------------------------------------------------------------------------
// Pose frame transform bench channels
// The block's own interfaces are reused; this file only adds a small bundle
// that carries the bench's view of the register file to the checker.
// ----------------------------------------------------------------------------
interface pft_shadow_if;
  logic [63:0] regs [8];
endinterface

[bench/pft_checker.sv]
// ----------------------------------------------------------------------------
// Pose frame transform checker
// Watches pose, result and register channels, predicts each result in
// fixed point and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pft_checker (
  input  logic         clk,
  input  logic         rst,
  pft_pose_if.sink     pose,
  pft_result_if.sink   result,
  pft_cfg_if.sink      cfg,
  pft_shadow_if        shadow,
  output int           fail_count,
  output int           pending
);

  typedef logic signed [63:0] s64_t;

  pft_pkg::res_t expected_q [$];

  function automatic s64_t clamp32(s64_t v, ref logic flag);
    if (v > 64'sh7fffffff) begin
      flag = 1'b1;
      return 64'sh7fffffff;
    end
    if (v < -64'sh80000000) begin
      flag = 1'b1;
      return -64'sh80000000;
    end
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic pft_pkg::res_t transform_pose(pft_pkg::pose_t ps);
    s64_t p [3];
    s64_t a [3][3];
    s64_t off [3];
    s64_t r [3][3];
    s64_t rt [3][3];
    s64_t m [3][3];
    s64_t t [3];
    s64_t q [4];
    s64_t x, y, z, w, xx, yy, zz, xy, xz, yz, xw, yw, zw, u, acc, tr, s, f, sc;
    logic ovf, junk;
    int i, j, k;
    pft_pkg::res_t o;
    ovf = 0;
    junk = 0;
    p[0] = ps.px; p[1] = ps.py; p[2] = ps.pz;
    x = ps.qx; y = ps.qy; z = ps.qz; w = ps.qw;
    xx = (x * x) >>> 29; yy = (y * y) >>> 29; zz = (z * z) >>> 29;
    xy = (x * y) >>> 29; xz = (x * z) >>> 29; yz = (y * z) >>> 29;
    xw = (x * w) >>> 29; yw = (y * w) >>> 29; zw = (z * w) >>> 29;
    a[0][0] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_0][31:0]));
    a[0][1] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_0][63:32]));
    a[0][2] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_1][31:0]));
    a[1][0] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_1][63:32]));
    a[1][1] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_2][31:0]));
    a[1][2] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_2][63:32]));
    a[2][0] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_3][31:0]));
    a[2][1] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_PAIR_3][63:32]));
    a[2][2] = s64_t'($signed(shadow.regs[pft_pkg::REG_ROT_LAST][31:0]));
    off[0] = s64_t'($signed(shadow.regs[pft_pkg::REG_OFFSET_XY][31:0]));
    off[1] = s64_t'($signed(shadow.regs[pft_pkg::REG_OFFSET_XY][63:32]));
    off[2] = s64_t'($signed(shadow.regs[pft_pkg::REG_OFFSET_Z][31:0]));
    sc = s64_t'({40'd0, shadow.regs[pft_pkg::REG_SCALE][23:0]});
    r[0][0] = (64'sd1 << 30) - (yy + zz); r[0][1] = xy - zw; r[0][2] = xz + yw;
    r[1][0] = xy + zw; r[1][1] = (64'sd1 << 30) - (xx + zz); r[1][2] = yz - xw;
    r[2][0] = xz - yw; r[2][1] = yz + xw; r[2][2] = (64'sd1 << 30) - (xx + yy);
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) rt[i][j] = clamp32(r[j][i], junk);
    for (i = 0; i < 3; i++) begin
      u = 0;
      for (j = 0; j < 3; j++) u += (rt[i][j] * p[j]) >>> 30;
      t[i] = clamp32((-u * sc) >>> 16, ovf);
    end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        acc = 0;
        for (k = 0; k < 3; k++) acc += (a[i][k] * rt[k][j]) >>> 30;
        m[i][j] = clamp32(acc, junk);
      end
    for (i = 0; i < 3; i++) begin
      acc = off[i];
      for (k = 0; k < 3; k++) acc += (a[i][k] * t[k]) >>> 30;
      o.pos[2 - i] = pft_pkg::word_t'(clamp32(acc, ovf));
    end
    // q[0..2] are x, y, z and q[3] is w.
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      s = s64_t'(root64(64'(tr + (64'sd1 << 30)) << 30));
      q[3] = s >>> 1;
      f = s64_t'((64'd1 << 59) / 64'(s));
      q[0] = clamp32(((m[2][1] - m[1][2]) * f) >>> 30, junk);
      q[1] = clamp32(((m[0][2] - m[2][0]) * f) >>> 30, junk);
      q[2] = clamp32(((m[1][0] - m[0][1]) * f) >>> 30, junk);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      s = s64_t'(root64(64'(m[i][i] - m[j][j] - m[k][k] + (64'sd1 << 30)) << 30));
      q[i] = s >>> 1;
      f = s64_t'((64'd1 << 59) / 64'(s));
      q[3] = clamp32(((m[k][j] - m[j][k]) * f) >>> 30, junk);
      q[j] = clamp32(((m[j][i] + m[i][j]) * f) >>> 30, junk);
      q[k] = clamp32(((m[k][i] + m[i][k]) * f) >>> 30, junk);
    end
    for (i = 0; i < 4; i++) o.quat[3 - i] = pft_pkg::word_t'(clamp32(q[i], junk));
    o.time_tag = ps.time_tag;
    o.ovf = ovf;
    return o;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %h, got %h", name, exp_v, got);
      fail_count++;
    end
  endtask

  always_ff @(posedge clk) begin
    pft_pkg::pose_t ps;
    pft_pkg::res_t e;
    if (rst) begin
      shadow.regs[0] <= 64'd1073741824; shadow.regs[1] <= 0;
      shadow.regs[2] <= 64'd1073741824; shadow.regs[3] <= 0;
      shadow.regs[4] <= 64'd1073741824; shadow.regs[5] <= 0;
      shadow.regs[6] <= 0; shadow.regs[7] <= 64'd65536;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          pft_pkg::REG_ROT_LAST, pft_pkg::REG_OFFSET_Z:
            shadow.regs[cfg.index] <= {32'd0, cfg.data[31:0]};
          pft_pkg::REG_SCALE:
            shadow.regs[cfg.index] <= {40'd0, cfg.data[23:0]};
          default:
            shadow.regs[cfg.index] <= cfg.data;
        endcase
      end
      if (pose.valid && pose.ready) begin
        ps = '{pose.time_tag, pose.pos_x, pose.pos_y, pose.pos_z,
               pose.quat_x, pose.quat_y, pose.quat_z, pose.quat_w};
        expected_q.insert(expected_q.size(), transform_pose(ps));
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("time_tag_out", e.time_tag, result.time_tag_out);
          compare_field("out_pos_x", 64'(e.pos[2]), 64'(result.out_pos_x));
          compare_field("out_pos_y", 64'(e.pos[1]), 64'(result.out_pos_y));
          compare_field("out_pos_z", 64'(e.pos[0]), 64'(result.out_pos_z));
          compare_field("out_quat_x", 64'(e.quat[3]), 64'(result.out_quat_x));
          compare_field("out_quat_y", 64'(e.quat[2]), 64'(result.out_quat_y));
          compare_field("out_quat_z", 64'(e.quat[1]), 64'(result.out_quat_z));
          compare_field("out_quat_w", 64'(e.quat[0]), 64'(result.out_quat_w));
          compare_field("overflow", 64'(e.ovf), 64'(result.overflow));
        end
      end
    end
  end

  assign pending = expected_q.size();

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Pose frame transform testbench
// Drives directed and random poses under several frame settings with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY   = 40;
  localparam int IDLE_STOP = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   hold_off;
  bit   stim_done;

  pft_pose_if   pose ();
  pft_result_if result ();
  pft_cfg_if    cfg ();
  pft_shadow_if shadow ();

  pose_frame_transform dut (.clk(clk), .rst(rst), .pose(pose), .result(result), .cfg(cfg));
  pft_checker chk (.clk(clk), .rst(rst), .pose(pose), .result(result), .cfg(cfg),
                   .shadow(shadow), .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Roughly unit quaternion in Q2.30, or noise now and then.
  task automatic make_quat(output logic [31:0] q [4]);
    int k;
    if ($urandom_range(0, 7) == 0) begin
      for (k = 0; k < 4; k++) q[k] = rand_word();
    end else begin
      for (k = 0; k < 4; k++) q[k] = 32'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
      q[$urandom_range(0, 3)] = 32'(($urandom_range(0, 1) ? 1 : -1) * (1 << 30) - 17);
    end
  endtask

  // Valid stays high after a transaction; the next gap or the drain drops it.
  task automatic send_pose(logic [63:0] tag, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [31:0] q [4]);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      pose.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pose.valid    <= 1;
    pose.time_tag <= tag;
    pose.pos_x <= px; pose.pos_y <= py; pose.pos_z <= pz;
    pose.quat_x <= q[0]; pose.quat_y <= q[1]; pose.quat_z <= q[2]; pose.quat_w <= q[3];
    do @(posedge clk); while (!pose.ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic drain();
    pose.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_poses(int n);
    logic [31:0] q [4];
    int k;
    for (k = 0; k < n; k++) begin
      make_quat(q);
      send_pose({$urandom, $urandom}, rand_word(), rand_word(), rand_word(), q);
    end
  endtask

  // Receiver: random stalls, one long hold-off while the sender keeps going.
  initial begin
    int wait_n;
    result.ready <= 0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        result.ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (wait_n == 0) begin
        result.ready <= 1;
        @(posedge clk);
      end else begin
        result.ready <= 0;
        repeat (wait_n) @(posedge clk);
        result.ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pose.valid && pose.ready) || (result.valid && result.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_STOP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] q [4];
    logic [31:0] ident [4];
    int          ph;
    int          k;
    stim_done = 0;
    hold_off  = 0;
    rst = 1;
    pose.valid <= 0; pose.time_tag <= 0;
    pose.pos_x <= 0; pose.pos_y <= 0; pose.pos_z <= 0;
    pose.quat_x <= 0; pose.quat_y <= 0; pose.quat_z <= 0; pose.quat_w <= 0;
    cfg.valid <= 0; cfg.index <= pft_pkg::REG_ROT_PAIR_0; cfg.data <= 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    ident = '{0, 0, 0, 32'h40000000};
    // Directed: identity, half turns on each axis (non-positive trace), extremes.
    send_pose(64'h0, 0, 0, 0, ident);
    send_pose('1, 32'h7fffffff, 32'h80000000, 32'h00010000, ident);
    q = '{32'h40000000, 0, 0, 0}; send_pose(64'h1, 32'h00010000, 0, 0, q);
    q = '{0, 32'h40000000, 0, 0}; send_pose(64'h2, 0, 32'h00010000, 0, q);
    q = '{0, 0, 32'h40000000, 0}; send_pose(64'h3, 0, 0, 32'h00010000, q);
    q = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    send_pose(64'h4, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, q);
    q = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    send_pose(64'h5, 32'h80000000, 32'h80000000, 32'h80000000, q);
    q = '{0, 0, 0, 0}; send_pose(64'h6, 32'h12345678, 32'hfedcba98, 32'h0, q);
    q = '{32'h2d413ccd, 0, 0, 32'h2d413ccd}; send_pose(64'h7, 32'h00050000, 0, 0, q);
    q = '{32'hc0000000, 32'h20000000, 0, 32'h10000000};
    send_pose(64'h8, 32'hfff00000, 32'h00100000, 32'h7fff0000, q);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          // All-ones pairs, largest last entry and scale: saturation of matrix and position.
          for (k = 0; k < 4; k++) write_reg(3'(k), '1);
          write_reg(pft_pkg::REG_ROT_LAST, 64'h7fffffff);
          write_reg(pft_pkg::REG_OFFSET_XY, 64'h7fffffff_80000000);
          write_reg(pft_pkg::REG_OFFSET_Z, 64'h80000000);
          write_reg(pft_pkg::REG_SCALE, 64'hffffff);
        end
        1: begin
          for (k = 0; k < 4; k++) write_reg(3'(k), 64'h80000000_80000000);
          write_reg(pft_pkg::REG_ROT_LAST, 64'h80000000);
          write_reg(pft_pkg::REG_OFFSET_XY, 0);
          write_reg(pft_pkg::REG_OFFSET_Z, 64'h7fffffff);
          write_reg(pft_pkg::REG_SCALE, 0);
        end
        2: begin
          // Permutation frame with a small offset and half scale.
          write_reg(pft_pkg::REG_ROT_PAIR_0, 64'h40000000_00000000);
          write_reg(pft_pkg::REG_ROT_PAIR_1, 0);
          write_reg(pft_pkg::REG_ROT_PAIR_2, 0);
          write_reg(pft_pkg::REG_ROT_PAIR_3, 64'h00000000_40000000);
          write_reg(pft_pkg::REG_ROT_LAST, 0);
          write_reg(pft_pkg::REG_ROT_PAIR_1, 64'h00000000_00000000);
          write_reg(pft_pkg::REG_ROT_PAIR_2, 64'h40000000_00000000);
          write_reg(pft_pkg::REG_OFFSET_XY, 64'h00030000_fffd0000);
          write_reg(pft_pkg::REG_OFFSET_Z, 64'h00010000);
          write_reg(pft_pkg::REG_SCALE, 64'h8000);
        end
        3, 4: begin
          for (k = 0; k < 8; k++) write_reg(3'(k), {$urandom, $urandom});
        end
        default: begin
          write_reg(pft_pkg::REG_ROT_PAIR_0, 64'd1073741824);
          write_reg(pft_pkg::REG_ROT_PAIR_1, 0);
          write_reg(pft_pkg::REG_ROT_PAIR_2, 64'd1073741824);
          write_reg(pft_pkg::REG_ROT_PAIR_3, 0);
          write_reg(pft_pkg::REG_ROT_LAST, 64'd1073741824);
          write_reg(pft_pkg::REG_OFFSET_XY, 0);
          write_reg(pft_pkg::REG_OFFSET_Z, 0);
          write_reg(pft_pkg::REG_SCALE, 64'd65536);
        end
      endcase
      cfg.valid <= 0;
      if (ph == 5) begin
        hold_off = 1;
        random_poses(100);
      end
      random_poses(ph == 5 ? 1000 : 80);
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pft_pkg.sv
rtl/core/pft_if.sv
rtl/core/pft_front.sv
rtl/core/pft_sqrt.sv
rtl/core/pft_recip.sv
rtl/core/pft_quat.sv
rtl/core/pose_frame_transform.sv
rtl/core/pft_checker.sv
bench/pft_tb_if.sv
bench/pft_checker.sv
bench/tb.sv
